// File: rtl/asm_pkg.sv
package asm_pkg;

  localparam int unsigned SegEntries = 16;
  localparam int unsigned IdxW = $clog2(SegEntries);
  localparam int unsigned CntW = $clog2(SegEntries + 1);
  localparam int unsigned ResultLimit = 16;
  localparam int unsigned ResW = $clog2(ResultLimit);

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFault   = 2'd1,
    StFull    = 2'd2,
    StBadRng  = 2'd3
  } status_e;

  typedef struct packed {
    logic       space;
    logic [63:0] start;
    logic [63:0] stop;
    logic [63:0] orig;
    logic [7:0]  target;
  } entry_t;

  // classification of one entry against an add range
  typedef struct packed {
    logic hit;      // same space and overlapping
    logic covered;  // fully inside the new range
    logic encloses; // strictly encloses the new range
    logic front;    // starts before the new range
  } cls_t;

endpackage

// File: rtl/asm_cmp_unit.sv
module asm_cmp_unit
  import asm_pkg::*;
(
  input  entry_t      entry_i,
  input  logic        space_i,
  input  logic [63:0] lo_i,
  input  logic [63:0] hi_i,
  output cls_t        cls_o
);
  // shared compare unit: one entry against one inclusive range per cycle
  logic ge_lo, le_hi, s_ge, e_le;
  assign s_ge  = entry_i.start >= lo_i;
  assign e_le  = entry_i.stop <= hi_i;
  assign ge_lo = entry_i.stop >= lo_i;
  assign le_hi = entry_i.start <= hi_i;
  assign cls_o.hit      = (entry_i.space == space_i) && ge_lo && le_hi;
  assign cls_o.covered  = s_ge && e_le;
  assign cls_o.encloses = !s_ge && (entry_i.stop > hi_i);
  assign cls_o.front    = !s_ge;
endmodule

// File: rtl/address_segment_map_unit.sv
// channel  | direction | signals
// request  | in        | start_i, busy_o, mode_i .. target_i
// result   | out       | result_valid_o, status_o .. last_o
// an add goes busy through a count walk, a decide step, a trim walk and a place
// an access searches the table for each chunk one entry per cycle through a single
// compare unit, stopping at the first hit
// a bad range add or a zero length access answers the next cycle without going busy
// reset clears all valid bits at once; entry contents are not reset
// the receiver cannot stall: each result shows for one cycle
module address_segment_map_unit
  import asm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic        space_i,
  input  logic        write_flag_i,
  input  logic [63:0] first_address_i,
  input  logic [63:0] last_address_i,
  input  logic [31:0] length_i,
  input  logic [7:0]  target_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [7:0]  chunk_target_o,
  output logic [63:0] chunk_address_o,
  output logic [31:0] chunk_length_o,
  output logic [63:0] segment_offset_o,
  output logic        chunk_write_o,
  output logic        chunk_space_o,
  output logic        last_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_COUNT = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_TRIM  = 7'b0001000,
    S_PLACE = 7'b0010000,
    S_SRCH  = 7'b0100000,
    S_CHUNK = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  entry_t           mem [SegEntries];
  logic [SegEntries-1:0] valid_q;

  logic        mode_q, space_q, wr_q;
  logic [63:0] lo_q, hi_q, addr_q;
  logic [32:0] cnt_q;
  logic [7:0]  tgt_q;
  logic [IdxW:0] idx_q;
  logic [CntW-1:0] used_q, removed_q;
  logic        split_q, found_q;
  logic [IdxW-1:0] split_idx_q;
  logic [ResW:0] res_q;
  entry_t      rd_q;

  logic [IdxW-1:0] idx;
  entry_t      cur;
  cls_t        cls;
  assign idx = idx_q[IdxW-1:0];
  assign cur = mem[idx];

  asm_cmp_unit u_cmp (
    .entry_i(cur),
    .space_i(space_q),
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .cls_o  (cls)
  );

  // lowest free slot, and the next one above it
  logic [IdxW-1:0] free0, free1;
  logic            has0;
  always_comb begin
    free0 = '0;
    free1 = '0;
    has0  = 1'b0;
    for (int i = SegEntries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free1 = free0;
        free0 = IdxW'(i);
        has0  = 1'b1;
      end
    end
  end

  logic [CntW+1:0] need;
  assign need = (CntW+2)'(used_q) - (CntW+2)'(removed_q) + (CntW+2)'(1) + (CntW+2)'(split_q);

  // chunk arithmetic
  logic [63:0] span;
  logic [32:0] cm1, n;
  logic        fits;
  assign span = rd_q.stop - addr_q;
  assign cm1  = cnt_q - 33'd1;
  assign fits = (span[63:32] != '0) || (cm1[31:0] <= span[31:0]);
  assign n    = fits ? cnt_q : {1'b0, span[31:0]} + 33'd1;

  logic emit;
  logic imm;
  logic [1:0] st_d;
  logic [7:0] ct_d;
  logic [63:0] ca_d, so_d;
  logic [31:0] cl_d;
  logic last_d;

  always_comb begin
    state_d = state_q;
    emit = 1'b0;
    imm = 1'b0;
    st_d = StOk;
    ct_d = '0;
    ca_d = '0;
    cl_d = '0;
    so_d = '0;
    last_d = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          // bad range add and zero length access answer at once
          if ((!mode_i && first_address_i > last_address_i) || (mode_i && length_i == '0))
            imm = 1'b1;
          else
            state_d = mode_i ? S_SRCH : S_COUNT;
        end
      end
      S_COUNT: if (idx_q == (IdxW+1)'(SegEntries - 1)) state_d = S_DEC;
      S_DEC: begin
        if (need > (CntW+2)'(SegEntries)) begin
          emit = 1'b1; st_d = StFull; state_d = S_IDLE;
        end else begin
          state_d = S_TRIM;
        end
      end
      S_TRIM: if (idx_q == (IdxW+1)'(SegEntries - 1)) state_d = S_PLACE;
      S_PLACE: begin
        emit = 1'b1;
        state_d = S_IDLE;
      end
      S_SRCH: begin
        if (idx_q == (IdxW+1)'(SegEntries - 1) || (valid_q[idx] && cls.hit))
          state_d = S_CHUNK;
      end
      S_CHUNK: begin
        emit = 1'b1;
        ca_d = addr_q;
        state_d = S_IDLE;
        if (!found_q) begin
          st_d = StFault;
        end else if (res_q == (ResW+1)'(ResultLimit - 1) && !fits) begin
          st_d = StFull;
        end else begin
          ct_d = rd_q.target;
          cl_d = n[31:0];
          so_d = addr_q - rd_q.orig;
          last_d = fits;
          if (!fits) state_d = S_SRCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      result_valid_o <= emit || imm;
      if (state_q == S_TRIM && valid_q[idx] && cls.hit && cls.covered &&
          !(split_q && split_idx_q == idx))
        valid_q[idx] <= 1'b0;
      if (state_q == S_PLACE) begin
        valid_q[free0] <= 1'b1;
        if (split_q) valid_q[free1] <= 1'b1;
      end
    end
  end

  // entry store and datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i; space_q <= space_i; wr_q <= write_flag_i;
      tgt_q <= target_i; addr_q <= first_address_i;
      cnt_q <= {1'b0, length_i};
      lo_q <= first_address_i;
      hi_q <= mode_i ? first_address_i : last_address_i;
      idx_q <= '0; used_q <= '0; removed_q <= '0; split_q <= 1'b0;
      found_q <= 1'b0; res_q <= '0;
      status_o <= (!mode_i) ? StBadRng : StOk;
      chunk_target_o <= '0;
      chunk_address_o <= mode_i ? first_address_i : '0;
      chunk_length_o <= '0; segment_offset_o <= '0;
      chunk_write_o <= mode_i & write_flag_i;
      chunk_space_o <= space_i;
      last_o <= 1'b1;
    end
    unique case (state_q)
      S_COUNT: begin
        if (valid_q[idx]) begin
          used_q <= used_q + CntW'(1);
          if (cls.hit && cls.covered) removed_q <= removed_q + CntW'(1);
          if (cls.hit && cls.encloses) begin
            split_q <= 1'b1; split_idx_q <= idx;
          end
        end
        idx_q <= (idx_q == (IdxW+1)'(SegEntries - 1)) ? '0 : idx_q + 1'b1;
      end
      S_TRIM: begin
        if (valid_q[idx] && cls.hit && !cls.covered) begin
          if (split_q && split_idx_q == idx) begin
            rd_q <= cur;
            mem[idx].stop <= lo_q - 64'd1;
          end else if (cls.front) begin
            mem[idx].stop <= lo_q - 64'd1;
          end else begin
            mem[idx].start <= hi_q + 64'd1;
          end
        end
        idx_q <= idx_q + 1'b1;
      end
      S_PLACE: begin
        mem[free0] <= '{space: space_q, start: lo_q, stop: hi_q, orig: lo_q,
                        target: tgt_q};
        if (split_q)
          mem[free1] <= '{space: space_q, start: hi_q + 64'd1, stop: rd_q.stop,
                          orig: rd_q.orig, target: rd_q.target};
      end
      S_SRCH: begin
        if (valid_q[idx] && cls.hit) begin
          found_q <= 1'b1; rd_q <= cur;
        end
        idx_q <= idx_q + 1'b1;
      end
      S_CHUNK: begin
        addr_q <= addr_q + {31'd0, n};
        lo_q <= addr_q + {31'd0, n};
        hi_q <= addr_q + {31'd0, n};
        cnt_q <= cnt_q - n;
        res_q <= res_q + 1'b1;
        idx_q <= '0;
        found_q <= 1'b0;
      end
      default: ;
    endcase
    if (emit) begin
      status_o <= st_d; chunk_target_o <= ct_d; chunk_address_o <= ca_d;
      chunk_length_o <= cl_d; segment_offset_o <= so_d; last_o <= last_d;
      chunk_write_o <= mode_q & wr_q; chunk_space_o <= space_q;
    end
  end

`ifndef SYNTHESIS
  a_full_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC && need > (CntW+2)'(SegEntries)) |=> $stable(valid_q))
    else $error("table changed on full");
  a_place_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PLACE |-> has0) else $error("no free slot at place");
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy_o) else $error("last while busy");
`endif
endmodule

// File: sim/segment_map_checker.sv
module segment_map_checker
  import asm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        mode_i,
  input  logic        space_i,
  input  logic        write_flag_i,
  input  logic [63:0] first_address_i,
  input  logic [63:0] last_address_i,
  input  logic [31:0] length_i,
  input  logic [7:0]  target_i,
  input  logic        result_valid_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  chunk_target_i,
  input  logic [63:0] chunk_address_i,
  input  logic [31:0] chunk_length_i,
  input  logic [63:0] segment_offset_i,
  input  logic        chunk_write_i,
  input  logic        chunk_space_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e     status;
    logic [7:0]  target;
    logic [63:0] address;
    logic [31:0] length;
    logic [63:0] offset;
    logic        write;
    logic        space;
    logic        last;
  } chunk_t;

  chunk_t chunk_queue[$];

  logic        seg_valid[SegEntries];
  logic        seg_space[SegEntries];
  logic [63:0] seg_start[SegEntries];
  logic [63:0] seg_end[SegEntries];
  logic [63:0] seg_orig[SegEntries];
  logic [7:0]  seg_target[SegEntries];

  int unsigned fails;

  initial begin
    fails = 0;
    for (int i = 0; i < SegEntries; i++) seg_valid[i] = 1'b0;
  end

  assign fail_count_o = fails;
  assign pending_o    = chunk_queue.size();

  function automatic int lowest_free();
    for (int i = 0; i < SegEntries; i++) if (!seg_valid[i]) return i;
    return -1;
  endfunction

  task automatic place_segment(input int i, input logic sp, input logic [63:0] s,
                               input logic [63:0] e, input logic [63:0] o,
                               input logic [7:0] t);
    if (i >= 0) begin
      seg_valid[i] = 1'b1;
      seg_space[i] = sp;
      seg_start[i] = s;
      seg_end[i] = e;
      seg_orig[i] = o;
      seg_target[i] = t;
    end
  endtask

  task automatic predict_add(input logic sp, input logic [63:0] lo, input logic [63:0] hi,
                             input logic [7:0] tgt);
    int used, removed, split, need;
    status_e st;
    logic [63:0] tail_end;
    chunk_t c;
    used = 0;
    removed = 0;
    split = -1;
    st = StOk;
    if (lo > hi) begin
      st = StBadRng;
    end else begin
      for (int i = 0; i < SegEntries; i++) begin
        if (seg_valid[i]) begin
          used++;
          if (seg_space[i] == sp && !(seg_end[i] < lo || seg_start[i] > hi)) begin
            if (seg_start[i] >= lo && seg_end[i] <= hi) removed++;
            else if (seg_start[i] < lo && seg_end[i] > hi) split = i;
          end
        end
      end
      need = used - removed + 1 + (split >= 0 ? 1 : 0);
      if (need > SegEntries) begin
        st = StFull;
      end else begin
        for (int i = 0; i < SegEntries; i++) begin
          if (seg_valid[i] && seg_space[i] == sp && i != split &&
              !(seg_end[i] < lo || seg_start[i] > hi)) begin
            if (seg_start[i] >= lo && seg_end[i] <= hi) seg_valid[i] = 1'b0;
            else if (seg_start[i] < lo) seg_end[i] = lo - 64'd1;
            else seg_start[i] = hi + 64'd1;
          end
        end
        place_segment(lowest_free(), sp, lo, hi, lo, tgt);
        if (split >= 0) begin
          tail_end = seg_end[split];
          seg_end[split] = lo - 64'd1;
          place_segment(lowest_free(), sp, hi + 64'd1, tail_end, seg_orig[split],
                        seg_target[split]);
        end
      end
    end
    c = '{st, 8'd0, 64'd0, 32'd0, 64'd0, 1'b0, sp, 1'b1};
    chunk_queue.push_back(c);
  endtask

  task automatic predict_access(input logic sp, input logic wr, input logic [63:0] start_addr,
                                input logic [31:0] len);
    logic [63:0] addr, count, span, n;
    int hit, k;
    chunk_t c;
    addr = start_addr;
    count = {32'd0, len};
    k = 0;
    if (count == 0) begin
      c = '{StOk, 8'd0, addr, 32'd0, 64'd0, wr, sp, 1'b1};
      chunk_queue.push_back(c);
    end
    while (count > 0) begin
      hit = -1;
      for (int i = 0; i < SegEntries; i++) begin
        if (hit < 0 && seg_valid[i] && seg_space[i] == sp &&
            seg_start[i] <= addr && addr <= seg_end[i]) hit = i;
      end
      if (hit < 0) begin
        c = '{StFault, 8'd0, addr, 32'd0, 64'd0, wr, sp, 1'b1};
        chunk_queue.push_back(c);
        return;
      end
      span = seg_end[hit] - addr;
      // last result slot: stop with an overflow marker if more remains
      if (k == ResultLimit - 1 && count - 64'd1 > span) begin
        c = '{StFull, 8'd0, addr, 32'd0, 64'd0, wr, sp, 1'b1};
        chunk_queue.push_back(c);
        return;
      end
      n = ((count - 64'd1 < span) ? count - 64'd1 : span) + 64'd1;
      count -= n;
      c = '{StOk, seg_target[hit], addr, n[31:0], addr - seg_orig[hit], wr, sp,
            count == 0};
      chunk_queue.push_back(c);
      k++;
      addr += n;
    end
  endtask

  always @(posedge clk_i) begin
    chunk_t exp_c;
    if (rst_ni && result_valid_i) begin
      if (chunk_queue.size() == 0) begin
        $error("result with no request waiting: address %0h", chunk_address_i);
        fails++;
      end else begin
        exp_c = chunk_queue.pop_front();
        if (status_i !== exp_c.status) begin
          $error("status expected %0h got %0h", exp_c.status, status_i);
          fails++;
        end
        if (chunk_target_i !== exp_c.target) begin
          $error("chunk_target expected %0h got %0h", exp_c.target, chunk_target_i);
          fails++;
        end
        if (chunk_address_i !== exp_c.address) begin
          $error("chunk_address expected %0h got %0h", exp_c.address, chunk_address_i);
          fails++;
        end
        if (chunk_length_i !== exp_c.length) begin
          $error("chunk_length expected %0h got %0h", exp_c.length, chunk_length_i);
          fails++;
        end
        if (segment_offset_i !== exp_c.offset) begin
          $error("segment_offset expected %0h got %0h", exp_c.offset, segment_offset_i);
          fails++;
        end
        if (chunk_write_i !== exp_c.write) begin
          $error("chunk_write expected %0h got %0h", exp_c.write, chunk_write_i);
          fails++;
        end
        if (chunk_space_i !== exp_c.space) begin
          $error("chunk_space expected %0h got %0h", exp_c.space, chunk_space_i);
          fails++;
        end
        if (last_i !== exp_c.last) begin
          $error("last expected %0h got %0h", exp_c.last, last_i);
          fails++;
        end
      end
    end
    // predict after checking so a result in the same edge pairs with older requests
    if (rst_ni && start_i && !busy_i) begin
      if (mode_i == 1'b0) predict_add(space_i, first_address_i, last_address_i, target_i);
      else predict_access(space_i, write_flag_i, first_address_i, length_i);
    end
  end

endmodule

// File: sim/tb_address_segment_map_unit.sv
module tb_address_segment_map_unit;
  import asm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        mode_i = 1'b0;
  logic        space_i = 1'b0;
  logic        write_flag_i = 1'b0;
  logic [63:0] first_address_i = '0;
  logic [63:0] last_address_i = '0;
  logic [31:0] length_i = '0;
  logic [7:0]  target_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [7:0]  chunk_target_o;
  logic [63:0] chunk_address_o;
  logic [31:0] chunk_length_o;
  logic [63:0] segment_offset_o;
  logic        chunk_write_o;
  logic        chunk_space_o;
  logic        last_o;
  int unsigned fail_count;
  int unsigned pending;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_ACCESS = 1'b1;
  localparam logic [63:0] TOP = 64'hFFFF_FFFF_FFFF_FFFF;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  address_segment_map_unit dut (.*);

  segment_map_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .space_i, .write_flag_i,
    .first_address_i, .last_address_i, .length_i, .target_i,
    .result_valid_i(result_valid_o), .status_i(status_o), .chunk_target_i(chunk_target_o),
    .chunk_address_i(chunk_address_o), .chunk_length_i(chunk_length_o),
    .segment_offset_i(segment_offset_o), .chunk_write_i(chunk_write_o),
    .chunk_space_i(chunk_space_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  bit allow_idle = 1'b1;

  // drive one request at a falling edge and hold it until accepted
  task automatic send_request(input logic md, input logic sp, input logic wr,
                              input logic [63:0] a, input logic [63:0] b,
                              input logic [31:0] len, input logic [7:0] tgt);
    if (allow_idle && $urandom_range(99) < 13) begin
      start_i = 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk_i);
    end
    start_i = 1'b1;
    mode_i = md;
    space_i = sp;
    write_flag_i = wr;
    first_address_i = a;
    last_address_i = b;
    length_i = len;
    target_i = tgt;
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic add_seg(input logic sp, input logic [63:0] a, input logic [63:0] b,
                         input logic [7:0] tgt);
    send_request(MODE_ADD, sp, 1'($urandom_range(1)), a, b, 32'($urandom), tgt);
  endtask

  task automatic access_range(input logic sp, input logic wr, input logic [63:0] a,
                              input logic [31:0] len);
    send_request(MODE_ACCESS, sp, wr, a, 64'($urandom), len, 8'($urandom));
  endtask

  function automatic logic [63:0] pick_address();
    logic [63:0] base;
    case ($urandom_range(9))
      0: base = {$urandom, $urandom};
      1, 2: base = TOP - 64'hFFF;
      3: base = 64'h8000_0000_0000_0000;
      default: base = 64'h0;
    endcase
    return base + {52'd0, 12'($urandom)};
  endfunction

  initial begin
    logic [63:0] a, b;
    logic [31:0] len;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    add_seg(1'b0, 64'd10, 64'd5, 8'h11);
    for (int i = 0; i < 16; i++) add_seg(1'b0, 64'h100 + i, 64'h100 + i, 8'(i));
    add_seg(1'b0, 64'h1000, 64'h1FFF, 8'hFF);        // table full
    access_range(1'b0, 1'b1, 64'h100, 32'd20);       // too many chunks
    access_range(1'b0, 1'b0, 64'h100, 32'd0);        // zero length
    access_range(1'b1, 1'b0, 64'h0, 32'd5);          // gap
    add_seg(1'b0, 64'h0, 64'hFFFF, 8'hAA);           // covers everything
    add_seg(1'b0, 64'h10, 64'h1F, 8'h01);            // split
    add_seg(1'b0, 64'h18, 64'h2F, 8'h02);            // front and back overlap
    access_range(1'b0, 1'b1, 64'h0, 32'h40);
    add_seg(1'b1, TOP - 64'hF, TOP, 8'h80);
    add_seg(1'b1, 64'h0, 64'hF, 8'h81);
    access_range(1'b1, 1'b1, TOP - 64'h7, 32'h10);   // wraps past the top
    access_range(1'b1, 1'b0, 64'h0, 32'hFFFF_FFFF);

    for (int n = 0; n < 160; n++) begin
      allow_idle = !(n >= 100 && n < 130);
      if (n == 80) begin
        start_i = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      a = pick_address();
      if ($urandom_range(99) < 45) begin
        case ($urandom_range(19))
          0: b = a - 64'd1 - 64'($urandom_range(100));   // bad range
          1: b = {$urandom, $urandom};
          2: b = a + 64'($urandom_range(16'hFFFF));
          default: b = a + 64'($urandom_range(16'h1FF));
        endcase
        if (b < a && $urandom_range(19) != 0) b = TOP;
        add_seg(1'($urandom_range(1)), a, b, 8'($urandom));
      end else begin
        len = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(16'h600));
        access_range(1'($urandom_range(1)), 1'($urandom_range(1)), a, len);
      end
    end
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
